FILE: rtl/waypoint_follow_controller_core_defines.svh
// Assertion macros used by the waypoint follower sequencer.
`ifndef WAYPOINT_FOLLOW_CONTROLLER_CORE_DEFINES_SVH
`define WAYPOINT_FOLLOW_CONTROLLER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/wfc_pkg.sv
// Types and constants of the waypoint follower.
`default_nettype none
package wfc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegLinLimit  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTurnLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegArrive    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAim       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWpTotal   = 3'd5;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdPose = 1'b1;

  localparam int unsigned CorW = 34;
  localparam int unsigned AngW = 28;
  localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
  localparam logic [15:0] InvGainQ16 = 16'd39797;

  typedef enum logic [2:0] {
    StIdle, StStart, StSetup, StIter, StDist, StDecide, StOut
  } state_e;

  typedef struct packed {
    logic start_goal;
    logic setup;
    logic iter;
    logic scale;
    logic decide;
    logic load_out;
  } dp_cmd_t;

  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        5'd0: r = 28'sd13176795;
        5'd1: r = 28'sd7778716;
        5'd2: r = 28'sd4110060;
        5'd3: r = 28'sd2086331;
        5'd4: r = 28'sd1047214;
        5'd5: r = 28'sd524117;
        5'd6: r = 28'sd262123;
        5'd7: r = 28'sd131069;
        default: r = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/wfc_ctrl.sv
// Sequencer for one item of the waypoint follower.
`default_nettype none
`include "waypoint_follow_controller_core_defines.svh"
module wfc_ctrl import wfc_pkg::*; #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pose_go_i,
  input  logic     needs_start_i,
  input  logic     out_free_i,
  output logic     busy_o,
  output dp_cmd_t  cmd_o,
  output logic [4:0] step_o
);
  state_e state_q, state_d;
  logic [4:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: if (pose_go_i) begin
        state_d = needs_start_i ? StStart : StSetup;
      end
      StStart: begin
        cmd_o.start_goal = 1'b1;
        state_d = StSetup;
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        step_d = '0;
        state_d = StIter;
      end
      StIter: begin
        cmd_o.iter = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == 5'(CordicSteps - 1)) state_d = StDist;
      end
      StDist: begin
        cmd_o.scale = 1'b1;
        state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d = StOut;
      end
      StOut: if (out_free_i) begin
        cmd_o.load_out = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign step_o = step_q;

  `WFC_ASSERT_IMP(a_iter_range, clk_i, rst_ni, state_q == StIter, step_q < 5'(CordicSteps), "step overrun")
  `WFC_ASSERT_NEXT(a_go_leaves_idle, clk_i, rst_ni, state_q == StIdle && pose_go_i, state_q != StIdle, "pose lost")
  `WFC_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "multiple commands")
endmodule
`default_nettype wire

FILE: rtl/wfc_datapath.sv
// CORDIC, waypoint table and command arithmetic of the waypoint follower.
`default_nettype none
module wfc_datapath import wfc_pkg::*; #(
  parameter int unsigned MaxWaypoints = 8,
  parameter int unsigned SlotW = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [4:0]         step_i,
  input  logic               load_we_i,
  input  logic [2:0]         load_slot_i,
  input  logic signed [15:0] load_x_i,
  input  logic signed [15:0] load_y_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic [15:0]        lin_limit_i,
  input  logic [15:0]        turn_limit_i,
  input  logic [15:0]        arrive_i,
  input  logic [15:0]        aim_i,
  input  logic [15:0]        gain_i,
  input  logic [3:0]         wp_total_i,
  output logic signed [15:0] fwd_o,
  output logic signed [15:0] turn_o,
  output logic signed [15:0] goal_x_o,
  output logic signed [15:0] goal_y_o,
  output logic signed [15:0] laps_o,
  output logic               adv_o
);
  logic signed [15:0] wp_x_q [MaxWaypoints];
  logic signed [15:0] wp_y_q [MaxWaypoints];
  logic [SlotW-1:0] next_q;
  logic signed [15:0] gx_q, gy_q, laps_q;
  logic signed [14:0] hd_q;
  logic signed [CorW-1:0] x_q, y_q;
  logic signed [AngW-1:0] z_q;
  logic signed [17:0] dist_q;
  logic signed [15:0] fwd_q, turn_q;
  logic adv_q;

  always_ff @(posedge clk_i) begin
    if (load_we_i && (32'(load_slot_i) < MaxWaypoints)) begin
      wp_x_q[SlotW'(load_slot_i)] <= load_x_i;
      wp_y_q[SlotW'(load_slot_i)] <= load_y_i;
    end
  end

  logic [SlotW:0] total;
  always_comb begin
    total = (wp_total_i < 4'd2) ? (SlotW+1)'(2) : (SlotW+1)'(wp_total_i);
    if (32'(wp_total_i) > MaxWaypoints) total = (SlotW+1)'(MaxWaypoints);
  end

  // goal selection for advance
  logic [SlotW-1:0] cur_slot, nxt_slot;
  logic signed [15:0] sel_x, sel_y;
  logic hit1;
  always_comb begin
    cur_slot = ({1'b0, next_q} >= total) ? '0 : next_q;
    nxt_slot = ({1'b0, cur_slot} + 1'b1 >= total) ? '0 : cur_slot + 1'b1;
    sel_x = cmd_i.start_goal ? wp_x_q[0] : wp_x_q[cur_slot];
    sel_y = cmd_i.start_goal ? wp_y_q[0] : wp_y_q[cur_slot];
    hit1 = (sel_x == wp_x_q[1]) && (sel_y == wp_y_q[1]);
  end

  // cordic step
  logic signed [CorW-1:0] dx, dy, sx, sy;
  always_comb begin
    dx = CorW'(signed'(17'(gx_q) - 17'(pose_x_i))) <<< 8;
    dy = CorW'(signed'(17'(gy_q) - 17'(pose_y_i))) <<< 8;
    sx = x_q >>> step_i;
    sy = y_q >>> step_i;
  end

  // decision
  logic signed [50:0] dprod;
  logic signed [AngW:0] err, errw;
  logic signed [16:0] e12, e12a;
  logic signed [35:0] fprod, tprod;
  logic signed [35:0] fr, tr;
  always_comb begin
    dprod = 51'(x_q) * 51'(signed'({1'b0, InvGainQ16})) + 51'sd8388608;
    err = (AngW+1)'(z_q) - ((AngW+1)'(hd_q) <<< 12);
    errw = err;
    if (err > (AngW+1)'(PiQ24)) errw = err - ((AngW+1)'(PiQ24) <<< 1);
    else if (err < -(AngW+1)'(PiQ24)) errw = err + ((AngW+1)'(PiQ24) <<< 1);
    e12 = 17'((errw + 29'sd2048) >>> 12);
    e12a = (e12 < 0) ? -e12 : e12;
    fprod = 36'(signed'({1'b0, gain_i})) * 36'(dist_q) + 36'sd128;
    tprod = 36'(signed'({1'b0, gain_i})) * 36'(e12) + 36'sd2048;
    fr = fprod >>> 8;
    tr = tprod >>> 12;
    if (fr > 36'(signed'({1'b0, lin_limit_i}))) fr = 36'(signed'({1'b0, lin_limit_i}));
    if (fr > 36'sd32767) fr = 36'sd32767;
    if (tr > 36'(signed'({1'b0, turn_limit_i}))) tr = 36'(signed'({1'b0, turn_limit_i}));
    if (tr < -36'(signed'({1'b0, turn_limit_i}))) tr = -36'(signed'({1'b0, turn_limit_i}));
    if (tr > 36'sd32767) tr = 36'sd32767;
    if (tr < -36'sd32768) tr = -36'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
      gx_q   <= '0;
      gy_q   <= '0;
      laps_q <= -16'sd1;
    end else begin
      if (cmd_i.start_goal) begin
        gx_q <= sel_x;
        gy_q <= sel_y;
        next_q <= SlotW'(1);
        laps_q <= hit1 ? 16'sd0 : -16'sd1;
      end else if (cmd_i.decide && (dist_q < 18'(signed'({1'b0, arrive_i})))) begin
        gx_q <= sel_x;
        gy_q <= sel_y;
        next_q <= nxt_slot;
        if (hit1 && laps_q != 16'sd32767) laps_q <= laps_q + 16'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_goal || cmd_i.setup) begin
      hd_q   <= pose_heading_i;
    end
    if (cmd_i.setup) begin
      if (dx < 0) begin
        x_q <= -dx;
        y_q <= -dy;
        z_q <= (dy >= 0) ? PiQ24 : -PiQ24;
      end else begin
        x_q <= dx;
        y_q <= dy;
        z_q <= '0;
      end
    end else if (cmd_i.iter) begin
      if (y_q < 0) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - atan_q24(step_i);
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + atan_q24(step_i);
      end
    end
    if (cmd_i.scale) dist_q <= 18'(dprod >>> 24);
    if (cmd_i.decide) begin
      adv_q  <= 1'b0;
      fwd_q  <= '0;
      turn_q <= '0;
      if (dist_q < 18'(signed'({1'b0, arrive_i}))) adv_q <= 1'b1;
      else if (e12a < 17'(signed'({1'b0, aim_i}))) fwd_q <= 16'(fr);
      else turn_q <= 16'(tr);
    end
  end

  assign fwd_o = fwd_q;
  assign turn_o = turn_q;
  assign goal_x_o = gx_q;
  assign goal_y_o = gy_q;
  assign laps_o = laps_q;
  assign adv_o = adv_q;
endmodule
`default_nettype wire

FILE: rtl/waypoint_follow_controller_core.sv
// Sequence: an accepted pose word is registered; Start follows for the first pose
// after reset or a load, then Setup, the CORDIC iterations, Dist, Decide and Out,
// where output stalls hold it. Input stalls while busy, so pose and load words
// enter only when idle; the shared CORDIC iterates one micro-rotation per cycle.
// A finished result waiting in the output register lets the next word in.
// Reset: asynchronous active low; config to defaults, goal 0, laps -1.
`default_nettype none
module waypoint_follow_controller_core import wfc_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 8,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [2:0]         slot_index_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] forward_velocity_o,
  output logic signed [15:0] turn_velocity_o,
  output logic signed [15:0] goal_x_o,
  output logic signed [15:0] goal_y_o,
  output logic signed [15:0] lap_count_o,
  output logic               goal_advanced_o
);
  localparam int unsigned SlotW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  logic [15:0] lin_q, turn_q, arr_q, aim_q, gain_q;
  logic [3:0] tot_q;
  logic needs_start_q;
  logic busy, in_acc, pose_go, out_free;
  dp_cmd_t dcmd;
  logic [4:0] step;
  logic signed [15:0] fwd, trn, gx, gy, laps;
  logic adv;
  logic signed [15:0] px_q, py_q;
  logic signed [14:0] ph_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = busy;
  assign in_acc = in_valid_i && !busy;
  assign pose_go = in_acc && (cmd_i == CmdPose);
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= 16'd2048; turn_q <= 16'd2048; arr_q <= 16'd3;
      aim_q <= 16'd41; gain_q <= 16'd2048; tot_q <= 4'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLinLimit:  lin_q  <= cfg_data_i;
        RegTurnLimit: turn_q <= cfg_data_i;
        RegArrive:    arr_q  <= cfg_data_i;
        RegAim:       aim_q  <= cfg_data_i;
        RegGain:      gain_q <= cfg_data_i;
        RegWpTotal:   tot_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) needs_start_q <= 1'b1;
    else if (in_acc && cmd_i == CmdLoad) needs_start_q <= 1'b1;
    else if (dcmd.start_goal) needs_start_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pose_go) begin
      px_q <= pose_x_i; py_q <= pose_y_i; ph_q <= pose_heading_i;
    end
  end

  wfc_ctrl #(.CordicSteps(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .pose_go_i(pose_go), .needs_start_i(needs_start_q),
    .out_free_i(out_free), .busy_o(busy), .cmd_o(dcmd), .step_o(step)
  );

  wfc_datapath #(.MaxWaypoints(MAX_WAYPOINTS), .SlotW(SlotW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd), .step_i(step),
    .load_we_i(in_acc && cmd_i == CmdLoad), .load_slot_i(slot_index_i),
    .load_x_i(point_x_i), .load_y_i(point_y_i),
    .pose_x_i(px_q), .pose_y_i(py_q), .pose_heading_i(ph_q),
    .lin_limit_i(lin_q), .turn_limit_i(turn_q), .arrive_i(arr_q), .aim_i(aim_q),
    .gain_i(gain_q), .wp_total_i(tot_q),
    .fwd_o(fwd), .turn_o(trn), .goal_x_o(gx), .goal_y_o(gy), .laps_o(laps), .adv_o(adv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (dcmd.load_out) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (dcmd.load_out) begin
      forward_velocity_o <= fwd; turn_velocity_o <= trn;
      goal_x_o <= gx; goal_y_o <= gy; lap_count_o <= laps; goal_advanced_o <= adv;
    end
  end
endmodule
`default_nettype wire

FILE: bench/waypoint_follow_controller_core_test.sv
// Self-checking bench for the waypoint follower core: random loads, poses and register settings.
`default_nettype none
module waypoint_follow_controller_core_test import wfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] laps;
    logic               adv;
  } motion_cmd_t;

  class motion_scoreboard;
    longint lin_lim, turn_lim, arrive, aim, gain, wp_total;
    longint wp_x [8];
    longint wp_y [8];
    int unsigned next_slot;
    longint goal_x, goal_y, laps;
    bit needs_start;
    motion_cmd_t pending_cmds [$];
    int mismatches;
    longint atan_tab [16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                              262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                              1024, 512};

    function new();
      lin_lim = 2048; turn_lim = 2048; arrive = 3; aim = 41; gain = 2048; wp_total = 5;
      foreach (wp_x[i]) begin
        wp_x[i] = 0; wp_y[i] = 0;
      end
      next_slot = 0; goal_x = 0; goal_y = 0; laps = -1; needs_start = 1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        RegLinLimit:  lin_lim = val;
        RegTurnLimit: turn_lim = val;
        RegArrive:    arrive = val;
        RegAim:       aim = val;
        RegGain:      gain = val;
        RegWpTotal:   wp_total = val[3:0];
        default: ;
      endcase
    endfunction

    function void vectoring(input longint dx, input longint dy,
                            output longint ang, output longint mag);
      longint x, y, z, nx;
      x = dx * 256; y = dy * 256; z = 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(PiQ24) : -longint'(PiQ24);
        x = -x; y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (y < 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      ang = z;
      mag = (x * longint'(InvGainQ16) + (longint'(1) << 23)) >>> 24;
    endfunction

    function void pick_goal(int unsigned s);
      goal_x = wp_x[s]; goal_y = wp_y[s];
      if (goal_x == wp_x[1] && goal_y == wp_y[1] && laps < 32767) laps++;
    endfunction

    function void note_input(logic cmd, logic [2:0] slot, logic signed [15:0] ptx,
                             logic signed [15:0] pty, logic signed [15:0] psx,
                             logic signed [15:0] psy, logic signed [14:0] hd);
      int unsigned total;
      longint ang, span, err, e12;
      motion_cmd_t r;
      if (cmd == CmdLoad) begin
        wp_x[slot] = ptx; wp_y[slot] = pty; needs_start = 1;
        return;
      end
      total = (wp_total < 2) ? 2 : (wp_total > 8) ? 8 : int'(wp_total);
      if (needs_start) begin
        laps = -1; pick_goal(0); next_slot = 1; needs_start = 0;
      end
      vectoring(goal_x - longint'(psx), goal_y - longint'(psy), ang, span);
      err = ang - longint'(hd) * 4096;
      if (err > longint'(PiQ24)) err -= 2 * longint'(PiQ24);
      else if (err < -longint'(PiQ24)) err += 2 * longint'(PiQ24);
      e12 = (err + 2048) >>> 12;
      r.fwd = 0; r.turn = 0; r.adv = 0;
      if (span < arrive) begin
        if (next_slot >= total) next_slot = 0;
        pick_goal(next_slot);
        next_slot = (next_slot + 1 >= total) ? 0 : next_slot + 1;
        r.adv = 1;
      end else if (((e12 < 0) ? -e12 : e12) < aim) begin
        longint f;
        f = (gain * span + 128) >>> 8;
        if (f > lin_lim) f = lin_lim;
        if (f > 32767) f = 32767;
        r.fwd = f[15:0];
      end else begin
        longint t;
        t = (gain * e12 + 2048) >>> 12;
        if (t > turn_lim) t = turn_lim;
        if (t < -turn_lim) t = -turn_lim;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        r.turn = t[15:0];
      end
      r.gx = goal_x[15:0]; r.gy = goal_y[15:0]; r.laps = laps[15:0];
      pending_cmds = {pending_cmds, r};
    endfunction

    function void check_result(motion_cmd_t got);
      motion_cmd_t want;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word fwd=%0d turn=%0d",
                                       got.fwd, got.turn);
        return;
      end
      want = pending_cmds.pop_front();
      if (want.fwd !== got.fwd || want.turn !== got.turn || want.gx !== got.gx ||
          want.gy !== got.gy || want.laps !== got.laps || want.adv !== got.adv) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp fwd=%0d turn=%0d goal=(%0d,%0d) laps=%0d adv=%0b",
                    " | got fwd=%0d turn=%0d goal=(%0d,%0d) laps=%0d adv=%0b"},
                   want.fwd, want.turn, want.gx, want.gy, want.laps, want.adv,
                   got.fwd, got.turn, got.gx, got.gy, got.laps, got.adv);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_stall_o, cmd_i;
  logic [2:0] slot_index_i;
  logic signed [15:0] point_x_i, point_y_i, pose_x_i, pose_y_i;
  logic signed [14:0] pose_heading_i;
  logic out_valid_o, out_stall_i;
  logic signed [15:0] forward_velocity_o, turn_velocity_o, goal_x_o, goal_y_o, lap_count_o;
  logic goal_advanced_o;

  motion_scoreboard sb = new();
  int sender_idle, receiver_stall, quiet_cycles;

  waypoint_follow_controller_core u_top (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0; cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    in_valid_i = 0; cmd_i = 0; slot_index_i = 0; point_x_i = 0; point_y_i = 0;
    pose_x_i = 0; pose_y_i = 0; pose_heading_i = 0; out_stall_i = 0;
    sender_idle = 0; receiver_stall = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < receiver_stall);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{forward_velocity_o, turn_velocity_o, goal_x_o, goal_y_o,
                          lap_count_o, goal_advanced_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("watchdog expired");
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic send_word(logic cmd, logic [2:0] slot, logic signed [15:0] ptx,
                           logic signed [15:0] pty, logic signed [15:0] psx,
                           logic signed [15:0] psy, logic signed [14:0] hd);
    while ($urandom_range(99) < sender_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= cmd; slot_index_i <= slot;
    point_x_i <= ptx; point_y_i <= pty; pose_x_i <= psx; pose_y_i <= psy;
    pose_heading_i <= hd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, slot, ptx, pty, psx, psy, hd);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(2000))) - 16'sd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  // pose near the goal, aimed at it, or anywhere
  task automatic send_pose(int mode);
    longint ang, mag, h, px, py;
    px = $signed(16'($urandom)); py = $signed(16'($urandom));
    if (mode == 0) begin
      px = sb.goal_x + $urandom_range(8) - 4;
      py = sb.goal_y + $urandom_range(8) - 4;
    end else if (mode == 1) begin
      px = sb.goal_x + $urandom_range(4000) - 2000;
      py = sb.goal_y + $urandom_range(4000) - 2000;
    end
    if (px > 32767) px = 32767;
    if (px < -32768) px = -32768;
    if (py > 32767) py = 32767;
    if (py < -32768) py = -32768;
    sb.vectoring(sb.goal_x - px, sb.goal_y - py, ang, mag);
    if (mode == 1) h = (ang >>> 12) + $urandom_range(120) - 60;
    else h = longint'($urandom_range(25736)) - 12868;
    if (h > 12868) h = 12868;
    if (h < -12868) h = -12868;
    send_word(CmdPose, 3'($urandom), 16'($urandom), 16'($urandom),
              px[15:0], py[15:0], h[14:0]);
  endtask

  initial begin
    logic [15:0] cfgs [6][6] = '{
      '{16'd2048, 16'd2048, 16'd3, 16'd41, 16'd2048, 16'd5},
      '{16'd65535, 16'd65535, 16'd256, 16'd400, 16'd65535, 16'd8},
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2},
      '{16'd30000, 16'd30000, 16'd65535, 16'd65535, 16'd4096, 16'd15},
      '{16'd8192, 16'd1000, 16'd64, 16'd200, 16'd12000, 16'd1},
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}};
    int idle_tab [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{37, 37}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: fill the table, then extremes, zero offset, back quadrant
    send_word(CmdLoad, 0, 16'sd0, 16'sd0, 0, 0, 0);
    send_word(CmdLoad, 1, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    send_word(CmdLoad, 2, 16'sh8000, 16'sh8000, 0, 0, 0);
    send_word(CmdLoad, 3, 16'sh7fff, 16'sh8000, 0, 0, 0);
    send_word(CmdLoad, 4, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    send_word(CmdLoad, 5, -16'sd300, 16'sd500, 0, 0, 0);
    send_word(CmdLoad, 6, 16'sd100, -16'sd100, 0, 0, 0);
    send_word(CmdLoad, 7, 16'sd0, 16'sd0, 0, 0, 0);
    send_word(CmdPose, 0, 0, 0, 16'sd0, 16'sd0, 15'sd0);
    send_word(CmdPose, 0, 0, 0, 16'sh8000, 16'sh8000, 15'sd12868);
    send_word(CmdPose, 0, 0, 0, 16'sh7fff, 16'sh7fff, -15'sd12868);
    send_word(CmdPose, 0, 0, 0, 16'sh7fff, 16'sh7fff, 15'sd0);
    send_word(CmdPose, 0, 0, 0, 16'sh7fff, 16'sh7fff, 15'sd0);
    send_word(CmdPose, 0, 0, 0, 16'sd1000, -16'sd5, 15'sd12868);
    send_word(CmdPose, 0, 0, 0, 16'sd1000, 16'sd5, -15'sd12868);
    send_word(CmdPose, 0, 0, 0, 16'sh8000, 16'sh7fff, 15'sd3217);
    for (int k = 0; k < 6; k++) send_pose(0);
    drain();

    for (int p = 0; p < 6; p++) begin
      sender_idle = idle_tab[p % 4][0];
      receiver_stall = idle_tab[p % 4][1];
      for (int r = 0; r < 6; r++)
        write_reg(3'(r), (p == 5) ? ((r == 5) ? 16'($urandom_range(15)) : 16'($urandom))
                                  : cfgs[p][r]);
      cfg_valid_i <= 0;
      for (int n = 0; n < 255; n++) begin
        if ($urandom_range(99) < 6)
          send_word(CmdLoad, 3'($urandom), rand_coord(), rand_coord(), 16'($urandom),
                    16'($urandom), 15'($urandom));
        else
          send_pose($urandom_range(2));
        if (n == 127) drain();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_cmds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
